// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_ACTIVE(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed while active");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed around reset");

`endif

// File: hdl/swm_pkg.sv
package swm_pkg;

    localparam int WINDOW_SIZE = 16;
    localparam int COST_W      = 24;
    localparam int HELD_W      = 5;
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int AGE_W       = IDX_W;

    // One sorted entry: the sample and how many samples arrived after it.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [AGE_W-1:0]  age;
    } t_entry;

    // What a cell shows its neighbors; gt is high for an empty cell or a
    // stored value above the incoming sample.
    typedef struct packed {
        t_entry ent;
        logic   gt;
    } t_nbr;

endpackage

// File: hdl/swm_cell.sv
module swm_cell
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [COST_W-1:0] i_sample,
    input  logic              i_vld,
    input  logic              i_full,
    input  logic              i_sh,
    input  t_nbr              i_left,
    input  t_nbr              i_right,
    output t_nbr              o_nbr,
    output logic              o_sh
);

    t_entry r_ent;
    t_entry n_ent;
    t_nbr   own;
    t_nbr   cur_c;
    t_nbr   left_c;
    logic   evict;

    assign evict   = i_full && (r_ent.age == AGE_W'(WINDOW_SIZE - 1));
    assign own.ent = r_ent;
    assign own.gt  = !i_vld || (r_ent.cost > i_sample);
    assign o_nbr   = own;
    // Shift is high once the evicted entry lies at or below this cell.
    assign o_sh    = i_sh || evict;

    always_comb begin
        // Row with the evicted entry squeezed out.
        cur_c  = o_sh ? i_right : own;
        left_c = i_sh ? own : i_left;
        if (left_c.gt) begin
            n_ent     = left_c.ent;
            n_ent.age = left_c.ent.age + AGE_W'(1);
        end else if (cur_c.gt) begin
            n_ent.cost = i_sample;
            n_ent.age  = '0;
        end else begin
            n_ent     = cur_c.ent;
            n_ent.age = cur_c.ent.age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= n_ent;
        end
    end

endmodule

// File: hdl/sliding_window_median.sv
// Channel  Direction  Handshake                          Payload
// sample   in         i_sample_valid / o_sample_ready    i_sample_cost
// median   out        o_median_valid / i_median_ready    o_median_cost, o_held_count
//
// A sample beat enters the sorted cell row in the cycle it is accepted; its
// median is then registered at the output once the output register is free.
// A new sample can be taken every cycle while the output drains.
// Reset (synchronous) empties the window and drops any pending result.
// A stalled output holds one result plus one in the cells, then input stalls.
module sliding_window_median
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    input  logic [COST_W-1:0] i_sample_cost,
    output logic              o_median_valid,
    input  logic              i_median_ready,
    output logic [COST_W-1:0] o_median_cost,
    output logic [HELD_W-1:0] o_held_count
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_pend;
    logic              r_out_vld;
    logic [COST_W-1:0] r_median;
    logic [HELD_W-1:0] r_held;
    logic              full;
    logic              accept;
    logic              load_out;
    logic [IDX_W-1:0]  med_idx;
    t_nbr              nbr [WINDOW_SIZE];
    logic              sh  [WINDOW_SIZE+1];
    t_nbr              edge_lo;
    t_nbr              edge_hi;

    assign full           = (r_count == CNT_W'(WINDOW_SIZE));
    assign load_out       = r_pend && (!r_out_vld || i_median_ready);
    assign o_sample_ready = !r_pend || load_out;
    assign accept         = i_sample_valid && o_sample_ready;
    assign n_count        = full ? r_count : r_count + CNT_W'(1);
    assign med_idx        = IDX_W'(r_count >> 1);

    // Below the row nothing is greater; above it every slot is empty.
    assign edge_lo.ent = '0;
    assign edge_lo.gt  = 1'b0;
    assign edge_hi.ent = '0;
    assign edge_hi.gt  = 1'b1;
    assign sh[0]       = 1'b0;

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        swm_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (accept),
            .i_sample (i_sample_cost),
            .i_vld    (CNT_W'(g) < r_count),
            .i_full   (full),
            .i_sh     (sh[g]),
            .i_left   ((g == 0) ? edge_lo : nbr[(g == 0) ? 0 : g - 1]),
            .i_right  ((g == WINDOW_SIZE - 1) ? edge_hi
                                              : nbr[(g == WINDOW_SIZE - 1) ? g : g + 1]),
            .o_nbr    (nbr[g]),
            .o_sh     (sh[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_median_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_median <= nbr[med_idx].ent.cost;
            r_held   <= HELD_W'(r_count);
        end
    end

    assign o_median_valid = r_out_vld;
    assign o_median_cost  = r_median;
    assign o_held_count   = r_held;

endmodule

// File: hdl/swm_chk.sv
`include "assert_macros.svh"

module swm_chk
    import swm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_sample_ready,
    input logic              o_median_valid,
    input logic              i_median_ready,
    input logic [COST_W-1:0] o_median_cost,
    input logic [HELD_W-1:0] o_held_count
);

    // A stalled result beat stays offered with the same payload.
    `ASSERT_ACTIVE(a_out_hold, i_clk, i_rst_n,
        o_median_valid && !i_median_ready |=> o_median_valid)
    `ASSERT_ACTIVE(a_out_stable, i_clk, i_rst_n,
        o_median_valid && !i_median_ready |=> $stable(o_median_cost))
    // A result always reports at least the sample that caused it.
    `ASSERT_ACTIVE(a_held_nonzero, i_clk, i_rst_n,
        o_median_valid |-> o_held_count != '0)
    // The input is only held off by a result that is waiting downstream.
    `ASSERT_ACTIVE(a_in_stall_cause, i_clk, i_rst_n,
        !o_sample_ready |-> o_median_valid && !i_median_ready)
    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> !o_median_valid)

endmodule

bind sliding_window_median swm_chk u_swm_chk (.*);
